### hdl/palette_grid_upscaler_unit_defines.svh
// Assertion macros shared by the palette grid upscaler checkers.
// Included by the checker file; needs nothing else.
`ifndef PALETTE_GRID_UPSCALER_UNIT_DEFINES_SVH
`define PALETTE_GRID_UPSCALER_UNIT_DEFINES_SVH

// same-cycle implication, off during reset
`define PGU_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("pgu check failed");

// next-cycle implication, off during reset
`define PGU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("pgu check failed");

`endif

### hdl/pgu_pkg.sv
// Shared types and constants of the palette grid upscaler.
// No dependencies.
package pgu_pkg;

    localparam int POS_W       = 6;   // grid column / row position
    localparam int CW_W        = 8;   // canvas width register
    localparam int RH_W        = 4;   // row height register
    localparam int CODE_W      = 8;
    localparam int IDX_W       = 4;
    localparam int COLOR_W     = 16;
    localparam int ROW_W       = 9;
    localparam int SPAN_W      = 8;
    localparam int STORE_DEPTH = 16;
    localparam int MAX_SPANS   = 8;
    localparam int PROD_W      = 14;  // (gx+1)*canvas_width <= 64*255
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    localparam logic [COLOR_W-1:0] BLACK          = 16'h0000;
    localparam logic [CW_W-1:0]    CANVAS_W_RST   = 8'd120;
    localparam logic [RH_W-1:0]    ROW_HEIGHT_RST = 4'd6;

    typedef enum logic {
        OP_DRAW  = 1'b0,
        OP_WRITE = 1'b1
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CANVAS_WIDTH = 2'd0,
        CFG_ROW_HEIGHT   = 2'd1,
        CFG_PALETTE_EN   = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [CW_W-1:0] canvas_width;
        logic [RH_W-1:0] row_height;
        logic            palette_en;
    } t_cfg;

    // one classified cell, queued for span expansion
    typedef struct packed {
        logic [ROW_W-1:0]   row_base;
        logic [SPAN_W-1:0]  x0;
        logic [SPAN_W-1:0]  len;
        logic [COLOR_W-1:0] color;
        logic [RH_W-1:0]    spans;
        logic               last_cell;
    } t_job;

endpackage

### hdl/pgu_channels.sv
// Request channels of the palette grid upscaler: input, span output, config.
// Depends on pgu_pkg.
interface pgu_in_if;
    import pgu_pkg::*;
    logic               valid;
    logic               ready;
    logic               op;
    logic [CODE_W-1:0]  cell_code;
    logic               frame_start;
    logic [IDX_W-1:0]   entry_index;
    logic [COLOR_W-1:0] entry_color;
    modport source(output valid, op, cell_code, frame_start, entry_index, entry_color,
                   input ready);
    modport sink(input valid, op, cell_code, frame_start, entry_index, entry_color,
                 output ready);
endinterface

interface pgu_out_if;
    import pgu_pkg::*;
    logic               valid;
    logic               ready;
    logic [ROW_W-1:0]   pixel_row;
    logic [SPAN_W-1:0]  span_start;
    logic [SPAN_W-1:0]  span_length;
    logic [COLOR_W-1:0] span_color;
    logic               cell_done;
    logic               frame_done;
    modport source(output valid, pixel_row, span_start, span_length, span_color,
                   cell_done, frame_done, input ready);
    modport sink(input valid, pixel_row, span_start, span_length, span_color,
                 cell_done, frame_done, output ready);
endinterface

interface pgu_cfg_if;
    import pgu_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

### hdl/palette_grid_upscaler_unit.sv
// Palette grid upscaler top level: config registers, front end, job queue, span generator.
// Depends on pgu_pkg, pgu_channels, pgu_front, pgu_queue, pgu_back.
//
// Takes grid cell codes in row-major order (op draw) and palette writes (op write) on i_in,
// and sends one request per canvas span on o_out. Each drawn cell yields min(row_height, 8)
// spans on rows gy*row_height+dy covering columns gx*width/GRID_SIZE up to
// (gx+1)*width/GRID_SIZE; a row height of zero draws nothing but still steps the position.
// Rate: the span generator sends one span per clock while the output is not stalled, so a
// cell's spans leave back to back; input requests are taken one per clock while the front
// stage is free or the four-entry job queue has room; palette writes and empty cells stop
// in the front end. An accepted cell is registered in the front stage, then divided and
// written to the queue, popped into the generator and put in the output register as a span.
// Config writes (i_cfg, always ready) are only to be made while the block is idle.
module palette_grid_upscaler_unit #(
    parameter int GRID_SIZE       = 20,
    parameter int PALETTE_ENTRIES = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pgu_in_if.sink    i_in,
    pgu_out_if.source o_out,
    pgu_cfg_if.sink   i_cfg
);
    import pgu_pkg::*;

    t_cfg r_cfg;
    t_job push_job, pop_job;
    logic push, pop, full, empty;

    // config registers; writes beyond the list are dropped
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.canvas_width <= CANVAS_W_RST;
            r_cfg.row_height   <= ROW_HEIGHT_RST;
            r_cfg.palette_en   <= 1'b1;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_CANVAS_WIDTH: r_cfg.canvas_width <= i_cfg.data[CW_W-1:0];
                CFG_ROW_HEIGHT:   r_cfg.row_height   <= i_cfg.data[RH_W-1:0];
                CFG_PALETTE_EN:   r_cfg.palette_en   <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    // front: palette, position, geometry
    pgu_front #(
        .GRID_SIZE       (GRID_SIZE),
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_in    (i_in),
        .o_push  (push),
        .o_job   (push_job),
        .i_full  (full)
    );

    // decouples classification from span output
    pgu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_job   (pop_job),
        .o_empty (empty)
    );

    // back: one span per cycle while the output is not stalled
    pgu_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (pop_job),
        .i_empty (empty),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

### hdl/pgu_front.sv
// Front end: accepts requests, updates the palette and grid position,
// computes span geometry. Depends on pgu_pkg and pgu_channels.
module pgu_front #(
    parameter int GRID_SIZE       = 20,
    parameter int PALETTE_ENTRIES = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  pgu_pkg::t_cfg i_cfg,
    pgu_in_if.sink        i_in,
    output logic          o_push,
    output pgu_pkg::t_job o_job,
    input  logic          i_full
);
    import pgu_pkg::*;

    localparam logic [POS_W:0]  GRID_L   = (POS_W+1)'(GRID_SIZE);
    localparam logic [POS_W-1:0] GRID_LAST = POS_W'(GRID_SIZE - 1);
    localparam int PAL_LIMIT = (PALETTE_ENTRIES < STORE_DEPTH) ? PALETTE_ENTRIES : STORE_DEPTH;
    localparam logic [CODE_W:0] PAL_LIM  = (CODE_W+1)'(PAL_LIMIT);
    // x / GRID_SIZE as (x * RECIP) >> SHIFT, exact for x < 2**PROD_W
    localparam int SHIFT   = PROD_W + $clog2(GRID_SIZE);
    localparam int RECIP   = ((1 << SHIFT) + GRID_SIZE - 1) / GRID_SIZE;
    localparam int MUL_W   = PROD_W + SHIFT + 1;

    logic [POS_W-1:0]   r_col, r_row, n_col, n_row;
    logic [COLOR_W-1:0] r_pal [STORE_DEPTH];

    logic               r_a_vld;
    logic [PROD_W-1:0]  r_a_p0, r_a_p1;
    logic [ROW_W-1:0]   r_a_row_base;
    logic [COLOR_W-1:0] r_a_color;
    logic [RH_W-1:0]    r_a_spans;
    logic               r_a_last;

    logic               accept, draw, wr, load;
    logic [POS_W-1:0]   gx_raw, gy_raw, gx, gy;
    logic [COLOR_W-1:0] color;
    logic [RH_W-1:0]    spans;
    logic [PROD_W-1:0]  p0, p1;
    logic [MUL_W-1:0]   m0, m1;
    logic [SPAN_W-1:0]  x0, x1;

    assign i_in.ready = !r_a_vld || !i_full;
    assign accept     = i_in.valid && i_in.ready;
    assign draw       = accept && (t_op'(i_in.op) == OP_DRAW);
    assign wr         = accept && (t_op'(i_in.op) == OP_WRITE);

    // position, with frame restart and stray-position wrap
    always_comb begin
        gx_raw = i_in.frame_start ? '0 : r_col;
        gy_raw = i_in.frame_start ? '0 : r_row;
        gx     = ({1'b0, gx_raw} >= GRID_L) ? '0 : gx_raw;
        gy     = ({1'b0, gy_raw} >= GRID_L) ? '0 : gy_raw;
        if (gx == GRID_LAST) begin
            n_col = '0;
            n_row = (gy == GRID_LAST) ? '0 : gy + POS_W'(1);
        end else begin
            n_col = gx + POS_W'(1);
            n_row = gy;
        end
    end

    always_comb begin
        if (!i_cfg.palette_en || ({1'b0, i_in.cell_code} >= PAL_LIM)) begin
            color = BLACK;
        end else begin
            color = r_pal[i_in.cell_code[IDX_W-1:0]];
        end
    end

    assign spans = (i_cfg.row_height > RH_W'(MAX_SPANS)) ? RH_W'(MAX_SPANS) : i_cfg.row_height;
    assign p0    = PROD_W'(gx) * PROD_W'(i_cfg.canvas_width);
    assign p1    = (PROD_W'(gx) + PROD_W'(1)) * PROD_W'(i_cfg.canvas_width);
    assign load  = draw && (spans != '0);

    // second stage: divide by the grid size and push
    assign m0     = MUL_W'(r_a_p0) * MUL_W'(RECIP);
    assign m1     = MUL_W'(r_a_p1) * MUL_W'(RECIP);
    assign x0     = m0[SHIFT +: SPAN_W];
    assign x1     = m1[SHIFT +: SPAN_W];
    assign o_push = r_a_vld && !i_full;

    always_comb begin
        o_job.row_base  = r_a_row_base;
        o_job.x0        = x0;
        o_job.len       = x1 - x0;
        o_job.color     = r_a_color;
        o_job.spans     = r_a_spans;
        o_job.last_cell = r_a_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_a_vld <= 1'b0;
            for (int k = 0; k < STORE_DEPTH; k++) begin
                r_pal[k] <= BLACK;
            end
        end else begin
            if (draw) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (wr) begin
                r_pal[i_in.entry_index] <= i_in.entry_color;
            end
            if (load) begin
                r_a_vld <= 1'b1;
            end else if (o_push) begin
                r_a_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_a_p0       <= p0;
            r_a_p1       <= p1;
            r_a_row_base <= ROW_W'((POS_W+RH_W)'(gy) * (POS_W+RH_W)'(i_cfg.row_height));
            r_a_color    <= color;
            r_a_spans    <= spans;
            r_a_last     <= (gx == GRID_LAST) && (gy == GRID_LAST);
        end
    end

endmodule

### hdl/pgu_queue.sv
// Short job queue between front end and span generator.
// Depends on pgu_pkg.
module pgu_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pgu_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output pgu_pkg::t_job o_job,
    output logic          o_empty
);
    import pgu_pkg::*;

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QPTR_W:0]   r_cnt;

    assign o_full  = (r_cnt == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + QPTR_W'(1);
            if (i_pop)  r_rd <= r_rd + QPTR_W'(1);
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (QPTR_W+1)'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - (QPTR_W+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_job;
    end

endmodule

### hdl/pgu_back.sv
// Span generator: expands queued cells into one span per cycle, while the output is not
// stalled, into an output register. Depends on pgu_pkg and pgu_channels.
module pgu_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  pgu_pkg::t_job i_job,
    input  logic          i_empty,
    output logic          o_pop,
    pgu_out_if.source     o_out
);
    import pgu_pkg::*;

    t_job             r_job;
    logic             r_act;
    logic [RH_W-1:0]  r_left;
    logic [ROW_W-1:0] r_row;
    logic             r_ov;

    logic out_free, emit, last;

    assign out_free = !r_ov || o_out.ready;
    assign emit     = r_act && out_free;
    assign last     = (r_left == RH_W'(1));
    assign o_pop    = !i_empty && (!r_act || (emit && last));
    assign o_out.valid = r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_ov  <= 1'b0;
        end else begin
            if (o_pop) begin
                r_act <= 1'b1;
            end else if (emit && last) begin
                r_act <= 1'b0;
            end
            if (emit) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job  <= i_job;
            r_row  <= i_job.row_base;
            r_left <= i_job.spans;
        end else if (emit) begin
            r_row  <= r_row + ROW_W'(1);
            r_left <= r_left - RH_W'(1);
        end
        if (emit) begin
            o_out.pixel_row   <= r_row;
            o_out.span_start  <= r_job.x0;
            o_out.span_length <= r_job.len;
            o_out.span_color  <= r_job.color;
            o_out.cell_done   <= last;
            o_out.frame_done  <= last && r_job.last_cell;
        end
    end

endmodule

### hdl/pgu_checker.sv
// Port-level checks of the palette grid upscaler, bound to the top level.
// Depends on palette_grid_upscaler_unit_defines.svh and pgu_pkg.
`include "palette_grid_upscaler_unit_defines.svh"

module pgu_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        i_ready,
    input logic [pgu_pkg::ROW_W-1:0]   i_pixel_row,
    input logic [pgu_pkg::SPAN_W-1:0]  i_span_start,
    input logic [pgu_pkg::SPAN_W-1:0]  i_span_length,
    input logic [pgu_pkg::COLOR_W-1:0] i_span_color,
    input logic                        i_cell_done,
    input logic                        i_frame_done
);
    import pgu_pkg::*;

    // stalled span request holds its row, start, color and cell end
    `PGU_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, i_valid && !i_ready, i_valid && $stable(i_pixel_row) && $stable(i_span_start) && $stable(i_span_color) && $stable(i_cell_done))

    // frame end only on a cell's last span
    `PGU_ASSERT_NOW(a_frame_in_cell, i_clk, i_rst_n, i_valid && i_frame_done, i_cell_done)

    // spans of one cell come back to back, next row, same columns and color
    `PGU_ASSERT_NEXT(a_cell_cont, i_clk, i_rst_n, i_valid && i_ready && !i_cell_done, i_valid && (i_pixel_row == $past(i_pixel_row) + 9'd1) && (i_span_start == $past(i_span_start)) && (i_span_length == $past(i_span_length)) && (i_span_color == $past(i_span_color)))

endmodule

bind palette_grid_upscaler_unit pgu_checker u_pgu_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (o_out.valid),
    .i_ready       (o_out.ready),
    .i_pixel_row   (o_out.pixel_row),
    .i_span_start  (o_out.span_start),
    .i_span_length (o_out.span_length),
    .i_span_color  (o_out.span_color),
    .i_cell_done   (o_out.cell_done),
    .i_frame_done  (o_out.frame_done)
);
